>>> design/earm_pkg.sv
// shared constants and types for the euler angle rotation matrix block
// no dependencies
package earm_pkg;
    localparam int ANGLE_WIDTH = 16;
    localparam int OUT_WIDTH = 16;
    localparam int CORDIC_STEPS = 20;
    localparam logic signed [31:0] FULL_TURN = 32'sd23040;
    localparam logic signed [31:0] HALF_TURN = 32'sd11520;
    localparam logic signed [31:0] QUARTER_TURN = 32'sd5760;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic signed [33:0] t_q30;
    typedef logic signed [ANGLE_WIDTH-1:0] t_angle;
    typedef logic signed [OUT_WIDTH-1:0] t_out;

    function automatic logic signed [27:0] atan_deg(input int i);
        logic signed [27:0] t;
        unique case (i)
            0: t = 28'sd47185920;  1: t = 28'sd27855475;  2: t = 28'sd14718068;
            3: t = 28'sd7471121;   4: t = 28'sd3750058;   5: t = 28'sd1876857;
            6: t = 28'sd938658;    7: t = 28'sd469358;    8: t = 28'sd234682;
            9: t = 28'sd117342;    10: t = 28'sd58671;    11: t = 28'sd29335;
            12: t = 28'sd14668;    13: t = 28'sd7334;     14: t = 28'sd3667;
            15: t = 28'sd1833;     16: t = 28'sd917;      17: t = 28'sd458;
            18: t = 28'sd229;      default: t = 28'sd115;
        endcase
        return t;
    endfunction
endpackage

>>> design/earm_cordic.sv
// pipelined sine/cosine unit: angle fold then one cordic step per stage
// depends on earm_pkg
module earm_cordic (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  earm_pkg::t_angle       i_ang,
    output earm_pkg::t_q30         o_cos,
    output earm_pkg::t_q30         o_sin
);
    import earm_pkg::*;

    logic signed [31:0] w_a, w_m, w_r;
    logic n_neg;
    t_q30 r_x [CORDIC_STEPS+1];
    t_q30 r_y [CORDIC_STEPS+1];
    logic signed [27:0] r_z [CORDIC_STEPS+1];
    logic r_neg [CORDIC_STEPS+1];

    assign w_a = 32'(i_ang);

    // range reduction by compare and subtract, input is within two turns
    always_comb begin
        w_m = w_a;
        if (w_m >= FULL_TURN) w_m = w_m - FULL_TURN;
        else if (w_m <= -FULL_TURN) w_m = w_m + FULL_TURN;
        if (w_m < 0) w_m = w_m + FULL_TURN;
        if (w_m >= HALF_TURN) w_m = w_m - FULL_TURN;
        n_neg = 1'b0;
        w_r = w_m;
        if (w_m > QUARTER_TURN) begin
            w_r = HALF_TURN - w_m;
            n_neg = 1'b1;
        end else if (w_m < -QUARTER_TURN) begin
            w_r = -HALF_TURN - w_m;
            n_neg = 1'b1;
        end
    end

    // fold stage loads the cordic start values
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= 28'(w_r * 32'sd16384);
            r_neg[0] <= n_neg;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_deg(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_deg(g);
                end
            end
        end
    end

    assign o_cos = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign o_sin = r_y[CORDIC_STEPS];
endmodule

>>> design/earm_matrix.sv
// product stages forming the nine matrix entries from sines and cosines
// depends on earm_pkg
module earm_matrix (
    input  logic           i_clk,
    input  logic           i_en,
    input  earm_pkg::t_q30 i_ca, i_sa, i_cb, i_sb, i_cg, i_sg,
    output earm_pkg::t_out o_m [9]
);
    import earm_pkg::*;

    function automatic t_q30 mulq(input t_q30 a, input t_q30 b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'sd536870912;
        return t_q30'(p >>> 30);
    endfunction

    function automatic t_out to_out(input logic signed [35:0] v);
        logic signed [35:0] s;
        logic signed [35:0] one;
        one = 36'sd1 <<< (OUT_WIDTH - 2);
        s = (v + (36'sd1 <<< (31 - OUT_WIDTH))) >>> (32 - OUT_WIDTH);
        if (s > one) s = one;
        if (s < -one) s = -one;
        return t_out'(s);
    endfunction

    t_q30 r_ca, r_sa, r_cg, r_sg, r_cb, r_cacb, r_sacb;
    t_q30 r_p [9];
    t_q30 r_q [5];
    t_q30 r_cb2;
    t_q30 r_sx6, r_sx7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: pair products
            r_cacb <= mulq(i_ca, i_cb);
            r_sacb <= mulq(i_sa, i_cb);
            r_ca <= i_ca; r_sa <= i_sa; r_cg <= i_cg; r_sg <= i_sg; r_cb <= i_cb;
            r_p[6] <= mulq(i_sa, i_sb);
            r_p[7] <= mulq(i_ca, i_sb);
            r_p[2] <= mulq(i_sb, i_sg);
            r_p[5] <= mulq(i_sb, i_cg);
            // stage 2: remaining products
            r_q[0] <= mulq(r_ca, r_cg);
            r_q[1] <= mulq(r_sacb, r_sg);
            r_q[2] <= mulq(r_sa, r_cg);
            r_q[3] <= mulq(r_cacb, r_sg);
            r_q[4] <= mulq(r_ca, r_sg);
            r_p[0] <= mulq(r_sacb, r_cg);
            r_p[1] <= mulq(r_sa, r_sg);
            r_p[3] <= mulq(r_cacb, r_cg);
            r_p[4] <= r_p[2];
            r_p[8] <= r_p[5];
            r_cb2 <= r_cb;
            // stage 3: sums and rounding
            o_m[0] <= to_out(36'(r_q[0]) - 36'(r_q[1]));
            o_m[1] <= to_out(36'(r_q[2]) + 36'(r_q[3]));
            o_m[2] <= to_out(36'(r_p[4]));
            o_m[3] <= to_out(-36'(r_q[4]) - 36'(r_p[0]));
            o_m[4] <= to_out(-36'(r_p[1]) + 36'(r_p[3]));
            o_m[5] <= to_out(36'(r_p[8]));
            o_m[6] <= to_out(36'(r_sx6));
            o_m[7] <= to_out(-36'(r_sx7));
            o_m[8] <= to_out(36'(r_cb2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx6 <= r_p[6];
            r_sx7 <= r_p[7];
        end
    end
endmodule

>>> design/euler_angle_rotation_matrix_top.sv
// channel | signals                                  | direction
// in      | i_valid, o_stall, i_psi/theta/phi_deg    | in
// out     | o_valid, i_stall, o_x/y/z_axis_0..2      | out
// one word enters per cycle while o_stall is low; the stages are fold, 20 cordic steps,
// two product stages, one sum/round stage that is the output register
// the whole pipeline advances only when the output register is free or taken
// reset clears the valid bits; o_stall follows i_stall when a word is held
// depends on earm_pkg, earm_cordic, earm_matrix
module euler_angle_rotation_matrix_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  earm_pkg::t_angle    i_psi_deg,
    input  earm_pkg::t_angle    i_theta_deg,
    input  earm_pkg::t_angle    i_phi_deg,
    output logic                o_valid,
    input  logic                i_stall,
    output earm_pkg::t_out      o_x_axis_0, o_x_axis_1, o_x_axis_2,
    output earm_pkg::t_out      o_y_axis_0, o_y_axis_1, o_y_axis_2,
    output earm_pkg::t_out      o_z_axis_0, o_z_axis_1, o_z_axis_2
);
    import earm_pkg::*;

    localparam int LAT = CORDIC_STEPS + 4;

    logic w_en;
    logic [LAT-1:0] r_vld;
    t_q30 w_ca, w_sa, w_cb, w_sb, w_cg, w_sg;
    t_out w_m [9];

    assign w_en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    earm_cordic u_phi (.i_clk, .i_en(w_en), .i_ang(i_phi_deg), .o_cos(w_ca), .o_sin(w_sa));
    earm_cordic u_the (.i_clk, .i_en(w_en), .i_ang(i_theta_deg), .o_cos(w_cb), .o_sin(w_sb));
    earm_cordic u_psi (.i_clk, .i_en(w_en), .i_ang(i_psi_deg), .o_cos(w_cg), .o_sin(w_sg));

    earm_matrix u_mat (
        .i_clk, .i_en(w_en),
        .i_ca(w_ca), .i_sa(w_sa), .i_cb(w_cb), .i_sb(w_sb), .i_cg(w_cg), .i_sg(w_sg),
        .o_m(w_m)
    );

    assign o_x_axis_0 = w_m[0];
    assign o_x_axis_1 = w_m[1];
    assign o_x_axis_2 = w_m[2];
    assign o_y_axis_0 = w_m[3];
    assign o_y_axis_1 = w_m[4];
    assign o_y_axis_2 = w_m[5];
    assign o_z_axis_0 = w_m[6];
    assign o_z_axis_1 = w_m[7];
    assign o_z_axis_2 = w_m[8];
endmodule

>>> design/earm_checker.sv
// port-level checks for the rotation matrix block
// depends on earm_pkg and euler_angle_rotation_matrix_top
module earm_sva (
    input logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall,
    input earm_pkg::t_out o_x_axis_0, o_z_axis_2
);
    import earm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_axis_0)) else $error("out word dropped");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("stall without held word");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_z_axis_2 <= t_out'(1 <<< (OUT_WIDTH-2))
        && o_z_axis_2 >= -t_out'(1 <<< (OUT_WIDTH-2))) else $error("range");
endmodule

bind euler_angle_rotation_matrix_top earm_sva u_chk (.*);
